[src/spk_pkg.sv]
// ----------------------------------------------------------------------------
// spk_pkg: shared types and constants of the spectrum peak picker
// Peak table entry and command types used by the top level and the
// table slots, plus result kinds and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package spk_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int POS_W       = 16;
   localparam int SUM_W       = 28;
   localparam int RANK_W      = 3;
   localparam int KIND_W      = 2;
   localparam int SLOTS_W     = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 64;

   localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

   localparam logic [KIND_W-1:0] KIND_HIT     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PEAK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_SLOTS = 8'd1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] level;
      logic [POS_W-1:0]    where_at;
   } spk_entry_type;

   typedef struct packed {
      logic                clear;
      logic                shift;
      logic                insert;
      logic [SAMPLE_W-1:0] level;
      logic [POS_W-1:0]    where_at;
   } spk_cmd_type;

endpackage

`default_nettype wire

[src/spk_cell.sv]
// ----------------------------------------------------------------------------
// spk_cell: one slot of the descending peak table
// Holds one entry. On insertion it takes the new peak or its left neighbor's
// entry; on readout it takes its right neighbor's entry; on clear it zeroes.
// ----------------------------------------------------------------------------
`default_nettype none

module spk_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  spk_pkg::spk_cmd_type   cmd,
   input  wire                    enabled,
   input  wire                    ins_left,
   input  spk_pkg::spk_entry_type left_entry,
   input  spk_pkg::spk_entry_type right_entry,
   output spk_pkg::spk_entry_type entry,
   output logic                   ins_right
);
   import spk_pkg::*;

   spk_entry_type entry_ff;
   spk_entry_type entry_in;
   logic          smaller;

   assign smaller   = enabled && (entry_ff.level < cmd.level);
   assign ins_right = ins_left || smaller;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.clear) begin
         entry_in = '0;
      end else if (cmd.shift) begin
         entry_in = right_entry;
      end else if (cmd.insert && enabled) begin
         if (ins_left) begin
            entry_in = left_entry;
         end else if (smaller) begin
            entry_in.level    = cmd.level;
            entry_in.where_at = cmd.where_at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

[src/spectrum_peak_top_k.sv]
// ----------------------------------------------------------------------------
// spectrum_peak_top_k: streaming local-maximum peak picker with top-K table
// Judges each falling edge of the spectrum, reports threshold hits, keeps a
// descending peak table in a row of slots, and closes each spectrum with the
// table contents and a sum/maximum summary.
//
//   Channel   Direction  Content
//   req_      in         tdata {intensity, position}, tlast end_of_spectrum
//   rsp_      out        tdata {total, rank, level, where_at}, tuser kind,
//                        tlast final_res
//   csr_      in         register index and write data, always ready
//
// A sample is taken while idle when the output register is free or drains.
// A sample that ends a spectrum is followed by one peak transfer per table
// slot in use, read out by a shift through the slot row, and one summary.
// Reset is synchronous and leaves the table and all spectrum state at zero.
// A stalled rsp_ side holds the block; req_tready drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_peak_top_k #(
   parameter int TABLE_SLOTS = 8,
   parameter int MAX_SAMPLES = 4096
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // req_tdata: position[15:0], intensity[31:16]
   input  wire  [spk_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                 req_tlast,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: where_at[15:0], level[31:16], rank[34:32], total[62:35], 0
   output logic [spk_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: kind[1:0]
   output logic [spk_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire  [spk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [spk_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready
);
   import spk_pkg::*;

   localparam int UW = $clog2(TABLE_SLOTS + 1);
   localparam int CW = $clog2(MAX_SAMPLES + 1);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_EMIT    = 3'b010,
      ST_SUMMARY = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  thr_ff, thr_in;
   logic [SLOTS_W-1:0]   slots_ff, slots_in;
   logic [SAMPLE_W-1:0]  prev_lvl_ff, prev_lvl_in;
   logic [POS_W-1:0]     prev_pos_ff, prev_pos_in;
   logic                 have_prev_ff, have_prev_in;
   logic                 taken_ff, taken_in;
   logic [SUM_W-1:0]     run_sum_ff, run_sum_in;
   logic [SAMPLE_W-1:0]  run_max_ff, run_max_in;
   logic [CW-1:0]        sample_cnt_ff, sample_cnt_in;
   logic [UW-1:0]        emit_cnt_ff, emit_cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [POS_W-1:0]     rsp_where_ff, rsp_where_in;
   logic [SAMPLE_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [RANK_W-1:0]    rsp_rank_ff, rsp_rank_in;
   logic [SUM_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                 rsp_final_ff, rsp_final_in;

   logic [POS_W-1:0]     cur_pos;
   logic [SAMPLE_W-1:0]  cur_lvl;
   logic [5:0]           slots_wide;
   logic [5:0]           table_wide;
   logic [UW-1:0]        used;
   logic                 out_free;
   logic                 req_fire;
   logic                 rsp_load;
   logic                 counting;
   logic                 active;
   logic                 rising;
   logic                 falling;
   logic [SUM_W:0]       sum_ext;
   spk_cmd_type          cmd;

   spk_entry_type        slot_q [TABLE_SLOTS];
   logic [TABLE_SLOTS:0] ins_chain;

   assign cur_pos    = req_tdata[POS_W-1:0];
   assign cur_lvl    = req_tdata[POS_W+SAMPLE_W-1:POS_W];
   assign slots_wide = {2'b00, slots_ff};
   assign table_wide = 6'(TABLE_SLOTS);
   assign used       = UW'((slots_wide > table_wide) ? table_wide : slots_wide);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign counting   = sample_cnt_ff < CW'(MAX_SAMPLES);
   assign active     = counting && have_prev_ff && (used != '0);
   assign rising     = prev_lvl_ff < cur_lvl;
   assign falling    = prev_lvl_ff > cur_lvl;
   assign sum_ext    = {1'b0, run_sum_ff} + (SUM_W + 1)'(cur_lvl);

   assign ins_chain[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_slot
         localparam logic [UW-1:0] IDX = UW'(gi);
         spk_entry_type left_e;
         spk_entry_type right_e;
         if (gi == 0) begin : g_first
            assign left_e = '0;
         end else begin : g_mid
            assign left_e = slot_q[gi-1];
         end
         if (gi == TABLE_SLOTS - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_inner
            assign right_e = slot_q[gi+1];
         end
         spk_cell u_slot (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .enabled     (used > IDX),
            .ins_left    (ins_chain[gi]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (slot_q[gi]),
            .ins_right   (ins_chain[gi+1])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      slots_in      = slots_ff;
      prev_lvl_in   = prev_lvl_ff;
      prev_pos_in   = prev_pos_ff;
      have_prev_in  = have_prev_ff;
      taken_in      = taken_ff;
      run_sum_in    = run_sum_ff;
      run_max_in    = run_max_ff;
      sample_cnt_in = sample_cnt_ff;
      emit_cnt_in   = emit_cnt_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_where_in  = rsp_where_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_final_in  = rsp_final_ff;
      cmd           = '0;
      cmd.level     = prev_lvl_ff;
      cmd.where_at  = prev_pos_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD:  thr_in   = csr_data;
            CSR_PEAK_SLOTS: slots_in = csr_data[SLOTS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (counting) begin
                  sample_cnt_in = sample_cnt_ff + CW'(1);
                  if (active && rising) begin
                     taken_in = 1'b0;
                  end else if (active && falling) begin
                     taken_in   = 1'b1;
                     cmd.insert = !taken_ff;
                     if (prev_lvl_ff > thr_ff) begin
                        rsp_load     = 1'b1;
                        rsp_kind_in  = KIND_HIT;
                        rsp_where_in = prev_pos_ff;
                        rsp_level_in = prev_lvl_ff;
                        rsp_rank_in  = '0;
                        rsp_total_in = '0;
                        rsp_final_in = 1'b0;
                     end
                  end
                  run_sum_in   = sum_ext[SUM_W] ? SUM_LIMIT : sum_ext[SUM_W-1:0];
                  run_max_in   = (cur_lvl > run_max_ff) ? cur_lvl : run_max_ff;
                  prev_lvl_in  = cur_lvl;
                  prev_pos_in  = cur_pos;
                  have_prev_in = 1'b1;
               end
               if (req_tlast) begin
                  emit_cnt_in = '0;
                  state_in    = (used != '0) ? ST_EMIT : ST_SUMMARY;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_kind_in  = KIND_PEAK;
               rsp_where_in = slot_q[0].where_at;
               rsp_level_in = slot_q[0].level;
               rsp_rank_in  = RANK_W'(emit_cnt_ff);
               rsp_total_in = '0;
               rsp_final_in = 1'b0;
               cmd.shift    = 1'b1;
               emit_cnt_in  = emit_cnt_ff + UW'(1);
               if (emit_cnt_ff + UW'(1) == used) begin
                  state_in = ST_SUMMARY;
               end
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_kind_in   = KIND_SUMMARY;
               rsp_where_in  = '0;
               rsp_level_in  = run_max_ff;
               rsp_rank_in   = '0;
               rsp_total_in  = run_sum_ff;
               rsp_final_in  = 1'b1;
               cmd.clear     = 1'b1;
               prev_lvl_in   = '0;
               prev_pos_in   = '0;
               have_prev_in  = 1'b0;
               taken_in      = 1'b0;
               run_sum_in    = '0;
               run_max_in    = '0;
               sample_cnt_in = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= '0;
         slots_ff      <= '0;
         prev_lvl_ff   <= '0;
         prev_pos_ff   <= '0;
         have_prev_ff  <= 1'b0;
         taken_ff      <= 1'b0;
         run_sum_ff    <= '0;
         run_max_ff    <= '0;
         sample_cnt_ff <= '0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         slots_ff      <= slots_in;
         prev_lvl_ff   <= prev_lvl_in;
         prev_pos_ff   <= prev_pos_in;
         have_prev_ff  <= have_prev_in;
         taken_ff      <= taken_in;
         run_sum_ff    <= run_sum_in;
         run_max_ff    <= run_max_in;
         sample_cnt_ff <= sample_cnt_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_where_ff <= rsp_where_in;
      rsp_level_ff <= rsp_level_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_total_ff <= rsp_total_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_final_ff;
   assign rsp_tdata  = {1'b0, rsp_total_ff, rsp_rank_ff, rsp_level_ff, rsp_where_ff};

   // The summary transfer is loaded in the same cycle that clears the run.
   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUMMARY && out_free) |=> (run_sum_ff == '0 && !have_prev_ff))
      else $error("spectrum state not cleared with summary");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (emit_cnt_ff < used))
      else $error("peak readout beyond slots in use");

   a_emit_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_tvalid && rsp_tuser == KIND_PEAK))
      else $error("peak readout did not load a peak entry");

   a_sample_limit: assert property (@(posedge clock) disable iff (reset)
      sample_cnt_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond limit");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_fire)
      else $error("sample taken during readout");

endmodule

`default_nettype wire

[tb/spectrum_peak_top_k_test.sv]
// ----------------------------------------------------------------------------
// spectrum_peak_top_k_test: self-checking bench for the spectrum peak picker
// Streams spectra into the block and predicts every threshold hit, peak table
// entry and summary in a model kept inside the bench. The result stream is
// checked field by field in order. The run covers directed edge cases, many
// slot and threshold settings, a long receiver stall, a sender pause and
// random spectra with random gaps on both sides.
// ----------------------------------------------------------------------------
module spectrum_peak_top_k_test;
   import spk_pkg::*;

   localparam int TABLE_SLOTS   = 8;
   localparam int MAX_SAMPLES   = 4096;
   localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
   localparam int STALL_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 100;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [POS_W-1:0]    where_at;
      logic [SAMPLE_W-1:0] level;
      logic [RANK_W-1:0]   rank;
      logic [SUM_W-1:0]    total;
      logic                final_res;
   } peak_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;

   logic [SAMPLE_W-1:0] threshold_cfg = '0;
   logic [SLOTS_W-1:0]  slots_cfg = '0;
   logic [SAMPLE_W-1:0] prior_level;
   logic [POS_W-1:0]    prior_where;
   logic                prior_valid;
   logic                fall_claimed;
   logic [SAMPLE_W-1:0] peak_level_row [TABLE_SLOTS];
   logic [POS_W-1:0]    peak_where_row [TABLE_SLOTS];
   logic [SUM_W-1:0]    level_sum;
   logic [SAMPLE_W-1:0] level_max;
   int unsigned         spectrum_samples;
   peak_report_type     pending_reports [$];

   bit steady = 1'b0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int samples_sent = 0;

   spectrum_peak_top_k #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .MAX_SAMPLES(MAX_SAMPLES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready)
   );

   always #1 clock = ~clock;

   function automatic void clear_spectrum_state();
      prior_level = '0;
      prior_where = '0;
      prior_valid = 1'b0;
      fall_claimed = 1'b0;
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         peak_level_row[k] = '0;
         peak_where_row[k] = '0;
      end
      level_sum = '0;
      level_max = '0;
      spectrum_samples = 0;
   endfunction

   function automatic void push_report(logic [KIND_W-1:0] kind, logic [POS_W-1:0] where_at,
                                       logic [SAMPLE_W-1:0] level, logic [RANK_W-1:0] rank,
                                       logic [SUM_W-1:0] total, logic final_res);
      peak_report_type r;
      r.kind = kind;
      r.where_at = where_at;
      r.level = level;
      r.rank = rank;
      r.total = total;
      r.final_res = final_res;
      pending_reports.push_back(r);
   endfunction

   // A new peak goes before the first strictly smaller entry, else it is dropped.
   function automatic void insert_peak(logic [SAMPLE_W-1:0] level, logic [POS_W-1:0] where_at,
                                       int used);
      for (int k = 0; k < used; k++) begin
         if (peak_level_row[k] < level) begin
            for (int j = used - 1; j > k; j--) begin
               peak_level_row[j] = peak_level_row[j-1];
               peak_where_row[j] = peak_where_row[j-1];
            end
            peak_level_row[k] = level;
            peak_where_row[k] = where_at;
            return;
         end
      end
   endfunction

   function automatic void predict_sample(logic [POS_W-1:0] where_at,
                                          logic [SAMPLE_W-1:0] level, logic closing);
      int used;
      logic [SUM_W:0] wide_sum;
      used = (slots_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(slots_cfg);
      if (spectrum_samples < MAX_SAMPLES) begin
         spectrum_samples++;
         if (prior_valid && used > 0) begin
            if (prior_level < level) begin
               fall_claimed = 1'b0;
            end else if (prior_level > level) begin
               if (prior_level > threshold_cfg)
                  push_report(KIND_HIT, prior_where, prior_level, '0, '0, 1'b0);
               if (!fall_claimed) begin
                  insert_peak(prior_level, prior_where, used);
                  fall_claimed = 1'b1;
               end
            end
         end
         wide_sum = level_sum + level;
         level_sum = (wide_sum > SUM_LIMIT) ? SUM_LIMIT : wide_sum[SUM_W-1:0];
         if (level > level_max)
            level_max = level;
         prior_level = level;
         prior_where = where_at;
         prior_valid = 1'b1;
      end
      if (closing) begin
         for (int k = 0; k < used; k++)
            push_report(KIND_PEAK, peak_where_row[k], peak_level_row[k], k[RANK_W-1:0], '0, 1'b0);
         push_report(KIND_SUMMARY, '0, level_max, '0, level_sum, 1'b1);
         clear_spectrum_state();
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 250;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      peak_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %h data %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("where_at", 32'(want.where_at), 32'(rsp_tdata[15:0]));
            check_field("level", 32'(want.level), 32'(rsp_tdata[31:16]));
            check_field("rank", 32'(want.rank), 32'(rsp_tdata[34:32]));
            check_field("total", 32'(want.total), 32'(rsp_tdata[62:35]));
            check_field("pad", 32'd0, 32'(rsp_tdata[63]));
            check_field("final_res", 32'(want.final_res), 32'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** spectrum_peak_top_k: FAILED **");
         $finish;
      end
   end

   task automatic send_sample(input logic [POS_W-1:0] where_at, input logic [SAMPLE_W-1:0] level,
                              input logic closing);
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {level, where_at};
      req_tlast <= closing;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_sample(where_at, level, closing);
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_THRESHOLD)
         threshold_cfg = value;
      else if (index == CSR_PEAK_SLOTS)
         slots_cfg = value[SLOTS_W-1:0];
   endtask

   task automatic configure(input logic [SAMPLE_W-1:0] threshold, input logic [SLOTS_W-1:0] slots);
      write_reg(CSR_THRESHOLD, threshold);
      write_reg(CSR_PEAK_SLOTS, {{(CSR_DATA_W-SLOTS_W){1'b0}}, slots});
   endtask

   // Shapes: white noise, a random walk with rises and falls, four coarse
   // levels that give plateaus and ties, and small values with rare spikes.
   task automatic send_random_spectrum(input int len, input bit closes);
      int shape;
      int step;
      bit rising;
      logic [POS_W-1:0] where_at;
      logic [SAMPLE_W-1:0] level;
      shape = $urandom_range(3);
      where_at = 16'($urandom);
      level = 16'($urandom);
      rising = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
         case (shape)
            0: begin
               level = 16'($urandom);
            end
            1: begin
               if ($urandom_range(99) < 25)
                  rising = !rising;
               step = $urandom_range(4096);
               if (rising)
                  level = (level > 65535 - step) ? 16'hFFFF : 16'(level + step);
               else
                  level = (level < step) ? 16'h0000 : 16'(level - step);
            end
            2: begin
               level = 16'($urandom_range(3) * 16'h5555);
            end
            default: begin
               level = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(3));
            end
         endcase
         where_at = (shape == 0) ? 16'($urandom) : where_at + 16'($urandom_range(1, 64));
         send_sample(where_at, level, closes && (i == len - 1));
      end
   endtask

   task automatic test_reset_defaults();
      send_sample(16'h0010, 16'h0100, 1'b0);
      send_sample(16'h0011, 16'h0200, 1'b0);
      send_sample(16'h0012, 16'h0001, 1'b1);
   endtask

   task automatic test_directed_peaks();
      configure(16'h8000, 4'd3);
      send_sample(16'h0000, 16'hFFFF, 1'b0);
      send_sample(16'h0001, 16'h1000, 1'b0);
      send_sample(16'h0002, 16'h1000, 1'b0);
      send_sample(16'h0003, 16'h0000, 1'b0);
      send_sample(16'h0004, 16'h7000, 1'b0);
      send_sample(16'h0005, 16'h7000, 1'b0);
      send_sample(16'h0006, 16'h6FFF, 1'b0);
      send_sample(16'h0007, 16'h9000, 1'b0);
      send_sample(16'h0008, 16'h8000, 1'b0);
      send_sample(16'h0009, 16'h8001, 1'b0);
      send_sample(16'h000A, 16'h8000, 1'b0);
      send_sample(16'h000B, 16'h9000, 1'b0);
      send_sample(16'h000C, 16'h0001, 1'b0);
      send_sample(16'h000D, 16'h8000, 1'b0);
      send_sample(16'hFFFF, 16'h7FFF, 1'b0);
      send_sample(16'h1234, 16'hFFFF, 1'b1);
      send_sample(16'hAAAA, 16'h5555, 1'b1);
      configure(16'h0000, 4'd15);
      send_sample(16'h5555, 16'h0000, 1'b0);
      send_sample(16'h8001, 16'hFFFF, 1'b0);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hFFFF, 16'h0000, 1'b1);
   endtask

   task automatic test_slot_settings();
      logic [SLOTS_W-1:0] slot_list [4] = '{4'd1, 4'd8, 4'd0, 4'd9};
      logic [SAMPLE_W-1:0] limit_list [4] = '{16'hFFFF, 16'h0000, 16'h4000, 16'hC000};
      for (int s = 0; s < 4; s++) begin
         configure(limit_list[s], slot_list[s]);
         repeat (2) send_random_spectrum($urandom_range(2, 16), 1'b1);
      end
   endtask

   task automatic test_output_stall();
      configure(16'h2000, 4'd8);
      wait_drained();
      hold_req = 1'b1;
      send_random_spectrum(40, 1'b1);
      wait_drained();
   endtask

   task automatic test_sender_pause();
      send_random_spectrum(10, 1'b0);
      wait_drained();
      send_random_spectrum(10, 1'b1);
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      repeat (5) send_random_spectrum($urandom_range(4, 20), 1'b1);
      steady = 1'b0;
   endtask

   task automatic test_random_spectra();
      int spectra;
      int goal;
      logic [SAMPLE_W-1:0] threshold;
      spectra = 0;
      goal = samples_sent + RANDOM_ITEMS;
      while (samples_sent < goal) begin
         if (spectra % 4 == 0) begin
            case ($urandom_range(3))
               0: threshold = 16'h0000;
               1: threshold = 16'hFFFF;
               default: threshold = 16'($urandom);
            endcase
            configure(threshold, 4'($urandom_range(15)));
         end
         send_random_spectrum(($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 20), 1'b1);
         spectra++;
      end
   endtask

   initial begin
      clear_spectrum_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_peaks();
      test_slot_settings();
      test_output_stall();
      test_sender_pause();
      test_steady_stream();
      test_random_spectra();
      wait_drained();
      if (error_count == 0)
         $display("** spectrum_peak_top_k: PASSED **");
      else
         $display("** spectrum_peak_top_k: FAILED **");
      $finish;
   end

endmodule
